### sv/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TDATA_W      = 40;
    localparam int TUSER_W      = 3;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REQ_INSERT   = 3'd0,
        REQ_EXTRACT  = 3'd1,
        REQ_DECREASE = 3'd2,
        REQ_DELETE   = 3'd3,
        REQ_PEEK     = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_BADIDX     = 3'd3,
        ST_NOTSMALLER = 3'd4
    } st_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_DECODE,
        CMD_FETCH,
        CMD_SUP_RD,
        CMD_SUP_CMP,
        CMD_TK_LAST,
        CMD_TK_LOAD,
        CMD_SDN_L,
        CMD_SDN_R,
        CMD_SDN_CMP,
        CMD_OUT
    } cmd_op_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic idx_bad;
        logic not_smaller;
        logic pos_root;
        logic parent_gt;
        logic last_one;
        logic lc_out;
        logic stop_down;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/mhpq_dp.sv
// Datapath of the min-heap queue: heap memory, count, sift registers, result register.
`default_nettype none

module mhpq_dp #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mhpq_pkg::cmd_op_t   cmd,
    input  logic [2:0]          req_in,
    input  logic signed [31:0]  key_in,
    input  logic [3:0]          idx_in,
    output mhpq_pkg::dp_status_t stat,
    output logic signed [31:0]  out_value,
    output logic [2:0]          out_status,
    output logic [4:0]          out_count
);
    import mhpq_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = PW + 2;
    localparam int IW = ((CW > 4) ? CW : 4) + 1;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic signed [31:0] cur_reg, cur_next;
    logic signed [31:0] key_reg, key_next;
    logic [3:0]         idx_reg, idx_next;
    req_t               req_reg, req_next;
    logic signed [31:0] res_reg, res_next;
    st_t                sts_reg, sts_next;
    logic signed [31:0] lkey_reg, lkey_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic [2:0]         out_status_reg, out_status_next;
    logic [4:0]         out_count_reg, out_count_next;

    logic               mem_we;
    logic [PW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic [LW-1:0]      lc_w, rc_w, cnt_l;
    logic [PW-1:0]      parent, idx_pw, best_pos;
    logic [CW-1:0]      cnt_m1;
    logic [31:0]        cnt_wide;
    logic               rc_in, take_l, take_r;
    logic signed [31:0] bkey, best_key;

    // Index arithmetic.
    assign lc_w     = {1'b0, pos_reg, 1'b1};
    assign rc_w     = lc_w + LW'(1);
    assign cnt_l    = {{(LW-CW){1'b0}}, cnt_reg};
    assign rc_in    = rc_w < cnt_l;
    assign parent   = (pos_reg - PW'(1)) >> 1;
    assign idx_pw   = PW'(idx_reg);
    assign cnt_m1   = cnt_reg - CW'(1);
    assign cnt_wide = 32'(cnt_reg);

    // Pick the smaller child; the right one wins only on a strict compare.
    assign take_l   = lkey_reg < cur_reg;
    assign bkey     = take_l ? lkey_reg : cur_reg;
    assign take_r   = rc_in && (rdata_reg < bkey);
    assign best_pos = take_r ? rc_w[PW-1:0] : lc_w[PW-1:0];
    assign best_key = take_r ? rdata_reg : lkey_reg;

    always_comb
    begin
        stat.req         = req_reg;
        stat.full        = cnt_reg == CW'(CAPACITY);
        stat.empty       = cnt_reg == '0;
        stat.idx_bad     = {{(IW-4){1'b0}}, idx_reg} >= {{(IW-CW){1'b0}}, cnt_reg};
        stat.not_smaller = !(key_reg < rdata_reg);
        stat.pos_root    = pos_reg == '0;
        stat.parent_gt   = rdata_reg > cur_reg;
        stat.last_one    = cnt_reg == CW'(1);
        stat.lc_out      = lc_w >= cnt_l;
        stat.stop_down   = !take_l && !take_r;
    end

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = cur_reg;
        mem_raddr = '0;
        case (cmd)
            CMD_DECODE:
            begin
                if (req_reg == REQ_DECREASE || req_reg == REQ_DELETE)
                    mem_raddr = idx_pw;
            end
            CMD_SUP_RD:
            begin
                mem_raddr = parent;
                mem_we    = stat.pos_root;
            end
            CMD_SUP_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = stat.parent_gt ? rdata_reg : cur_reg;
            end
            CMD_TK_LAST: mem_raddr = cnt_m1[PW-1:0];
            CMD_SDN_L:
            begin
                mem_raddr = lc_w[PW-1:0];
                mem_we    = stat.lc_out;
            end
            CMD_SDN_R: mem_raddr = rc_w[PW-1:0];
            CMD_SDN_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = stat.stop_down ? cur_reg : best_key;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // Register updates.
    always_comb
    begin
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        sts_next        = sts_reg;
        lkey_next       = lkey_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        case (cmd)
            CMD_LOAD:
            begin
                req_next = req_t'(req_in);
                key_next = key_in;
                idx_next = idx_in;
                res_next = '0;
                sts_next = ST_OK;
            end
            CMD_DECODE:
            begin
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if (stat.full)
                            sts_next = ST_FULL;
                        else
                        begin
                            pos_next = cnt_reg[PW-1:0];
                            cur_next = key_reg;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    REQ_EXTRACT, REQ_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            sts_next = ST_EMPTY;
                            res_next = INT_MIN;
                        end
                    end
                    REQ_DECREASE, REQ_DELETE:
                    begin
                        if (stat.idx_bad)
                            sts_next = ST_BADIDX;
                    end
                    default: ;
                endcase
            end
            CMD_FETCH:
            begin
                case (req_reg)
                    REQ_EXTRACT, REQ_PEEK: res_next = rdata_reg;
                    REQ_DECREASE:
                    begin
                        if (stat.not_smaller)
                            sts_next = ST_NOTSMALLER;
                        else
                        begin
                            cur_next = key_reg;
                            pos_next = idx_pw;
                        end
                    end
                    REQ_DELETE:
                    begin
                        res_next = rdata_reg;
                        cur_next = INT_MIN;
                        pos_next = idx_pw;
                    end
                    default: ;
                endcase
            end
            CMD_SUP_CMP:
            begin
                if (stat.parent_gt)
                    pos_next = parent;
            end
            CMD_TK_LAST:
            begin
                cnt_next = cnt_m1;
                pos_next = '0;
            end
            CMD_TK_LOAD: cur_next = rdata_reg;
            CMD_SDN_R:   lkey_next = rdata_reg;
            CMD_SDN_CMP:
            begin
                if (!stat.stop_down)
                    pos_next = best_pos;
            end
            CMD_OUT:
            begin
                out_value_next  = res_reg;
                out_status_next = sts_reg;
                out_count_next  = cnt_wide[4:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        req_reg        <= req_next;
        res_reg        <= res_next;
        sts_reg        <= sts_next;
        lkey_reg       <= lkey_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

### sv/mhpq_ctrl.sv
// Controller state machine of the min-heap queue: sequences requests and owns the handshakes.
`default_nettype none

module mhpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  mhpq_pkg::dp_status_t stat,
    output mhpq_pkg::cmd_op_t    cmd
);
    import mhpq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DECODE  = 11'b000_0000_0010,
        S_FETCH   = 11'b000_0000_0100,
        S_SUP_RD  = 11'b000_0000_1000,
        S_SUP_CMP = 11'b000_0001_0000,
        S_TK_LAST = 11'b000_0010_0000,
        S_TK_LOAD = 11'b000_0100_0000,
        S_SDN_L   = 11'b000_1000_0000,
        S_SDN_R   = 11'b001_0000_0000,
        S_SDN_CMP = 11'b010_0000_0000,
        S_FINISH  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    state_t after_up;

    // A delete continues into root removal once its slot has climbed.
    assign after_up = (stat.req == REQ_DELETE) ? S_TK_LAST : S_FINISH;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = CMD_IDLE;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd = CMD_DECODE;
                case (stat.req)
                    REQ_INSERT:
                        state_next = stat.full ? S_FINISH : S_SUP_RD;
                    REQ_EXTRACT, REQ_PEEK:
                        state_next = stat.empty ? S_FINISH : S_FETCH;
                    REQ_DECREASE, REQ_DELETE:
                        state_next = stat.idx_bad ? S_FINISH : S_FETCH;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_FETCH:
            begin
                cmd = CMD_FETCH;
                case (stat.req)
                    REQ_EXTRACT:  state_next = S_TK_LAST;
                    REQ_DECREASE: state_next = stat.not_smaller ? S_FINISH : S_SUP_RD;
                    REQ_DELETE:   state_next = S_SUP_RD;
                    default:      state_next = S_FINISH;
                endcase
            end
            S_SUP_RD:
            begin
                cmd        = CMD_SUP_RD;
                state_next = stat.pos_root ? after_up : S_SUP_CMP;
            end
            S_SUP_CMP:
            begin
                cmd        = CMD_SUP_CMP;
                state_next = stat.parent_gt ? S_SUP_RD : after_up;
            end
            S_TK_LAST:
            begin
                cmd        = CMD_TK_LAST;
                state_next = stat.last_one ? S_FINISH : S_TK_LOAD;
            end
            S_TK_LOAD:
            begin
                cmd        = CMD_TK_LOAD;
                state_next = S_SDN_L;
            end
            S_SDN_L:
            begin
                cmd        = CMD_SDN_L;
                state_next = stat.lc_out ? S_FINISH : S_SDN_R;
            end
            S_SDN_R:
            begin
                cmd        = CMD_SDN_R;
                state_next = S_SDN_CMP;
            end
            S_SDN_CMP:
            begin
                cmd        = CMD_SDN_CMP;
                state_next = stat.stop_down ? S_FINISH : S_SDN_L;
            end
            S_FINISH:
            begin
                // Hold until the result register is free or drains this cycle.
                if (!out_valid_reg || m_tready)
                begin
                    cmd            = CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

### sv/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: controller, datapath and stream ports.
//
//  Channel  | Dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-------------------
//  s_*      | in  | key_value[31:0], entry_index[35:32], 0 pad  | req_type[2:0]
//  m_*      | out | result_value[31:0], entry_count[36:32], pad | status[2:0]
//
//  One request at a time; an insert or a decrease climbs level by level toward the root, an
//  extract sinks the new root level by level, and a delete does both. The single read port
//  of the heap memory paces each step: a climb step reads the parent and then compares, a
//  sink step reads the left and then the right child and then compares. Removing the only key skips the sink.
//  Peek and rejected requests take no sift steps.
//  Reset clears the entry count and the handshakes; the heap memory is not cleared.
//  The result waits in an output register, so the next request is taken and worked on
//  while m_tready is low; it stalls only when its own result is ready.
`default_nettype none

module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_value[31:0], entry_index[35:32], zero fill [39:36]
    input  logic [mhpq_pkg::TDATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [mhpq_pkg::TUSER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value[31:0], entry_count[36:32], zero fill [39:37]
    output logic [mhpq_pkg::TDATA_W-1:0]  m_tdata,
    // status[2:0]
    output logic [mhpq_pkg::TUSER_W-1:0]  m_tuser
);
    import mhpq_pkg::*;

    cmd_op_t            cmd;
    dp_status_t         stat;
    logic signed [31:0] out_value;
    logic [2:0]         out_status;
    logic [4:0]         out_count;

    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_in     (s_tuser[2:0]),
        .key_in     (s_tdata[31:0]),
        .idx_in     (s_tdata[35:32]),
        .stat       (stat),
        .out_value  (out_value),
        .out_status (out_status),
        .out_count  (out_count)
    );

    // Pack the result beat.
    assign m_tdata = {3'b000, out_count, out_value};
    assign m_tuser = out_status;

    // Once a request is taken, s_tready is low in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // An empty report carries the sentinel minimum and a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |->
            (m_tdata[31:0] == INT_MIN) && (m_tdata[36:32] == 5'd0))
        else $error("empty result with wrong value or count");

    // A full report comes only with the heap at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[36:32] == 5'(CAPACITY))
        else $error("full result below capacity");

endmodule

`default_nettype wire

### tb/sv/tb_min_heap_priority_queue.sv
// Testbench for the min-heap priority queue: directed and random requests checked against a heap model.
`default_nettype none

module tb_min_heap_priority_queue;
    import mhpq_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_MAX   = 10;

    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    // One result beat as the block reports it.
    typedef struct packed {
        logic signed [31:0] value;
        st_t                status;
        logic [4:0]         count;
    } heap_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;

    // Heap model: keys in array order and the number held.
    logic signed [31:0] heap_keys [CAPACITY];
    int unsigned        heap_fill = 0;

    heap_result_t due_results [$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           steady_flow = 1'b0;

    min_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------- heap model

    // Move the key at a slot toward the root while its parent is strictly greater.
    function automatic void heap_sift_up(input int unsigned slot);
        int unsigned        pos;
        int unsigned        up;
        logic signed [31:0] held;
        pos = slot;
        while (pos != 0)
        begin
            up = (pos - 1) / 2;
            if (!(heap_keys[up] > heap_keys[pos]))
                break;
            held           = heap_keys[up];
            heap_keys[up]  = heap_keys[pos];
            heap_keys[pos] = held;
            pos            = up;
        end
    endfunction

    // Remove the root, refill it from the last slot and sink it back into place.
    function automatic logic signed [31:0] heap_take_root();
        logic signed [31:0] root;
        logic signed [31:0] held;
        int unsigned        pos;
        int unsigned        best;
        int unsigned        lc;
        int unsigned        rc;
        root = heap_keys[0];
        heap_fill--;
        if (heap_fill > 0)
        begin
            heap_keys[0] = heap_keys[heap_fill];
            pos = 0;
            while (1'b1)
            begin
                best = pos;
                lc   = 2 * pos + 1;
                rc   = 2 * pos + 2;
                if (lc < heap_fill && heap_keys[lc] < heap_keys[best])
                    best = lc;
                if (rc < heap_fill && heap_keys[rc] < heap_keys[best])
                    best = rc;
                if (best == pos)
                    break;
                held            = heap_keys[pos];
                heap_keys[pos]  = heap_keys[best];
                heap_keys[best] = held;
                pos             = best;
            end
        end
        return root;
    endfunction

    // Serve one request on the model and return the result beat it must produce.
    function automatic heap_result_t heap_apply(input logic [2:0] req,
                                                input logic signed [31:0] key,
                                                input logic [3:0] slot);
        heap_result_t res;
        res.value  = '0;
        res.status = ST_OK;
        case (req)
            REQ_INSERT:
                if (heap_fill >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    heap_keys[heap_fill] = key;
                    heap_fill++;
                    heap_sift_up(heap_fill - 1);
                end
            REQ_EXTRACT:
                if (heap_fill == 0)
                begin
                    res.status = ST_EMPTY;
                    res.value  = INT_MIN;
                end
                else
                    res.value = heap_take_root();
            REQ_DECREASE:
                if (slot >= heap_fill)
                    res.status = ST_BADIDX;
                else if (!(key < heap_keys[slot]))
                    res.status = ST_NOTSMALLER;
                else
                begin
                    heap_keys[slot] = key;
                    heap_sift_up(slot);
                end
            REQ_DELETE:
                if (slot >= heap_fill)
                    res.status = ST_BADIDX;
                else
                begin
                    // Force the slot to the top, then pop it off as the root.
                    res.value       = heap_keys[slot];
                    heap_keys[slot] = INT_MIN;
                    heap_sift_up(slot);
                    void'(heap_take_root());
                end
            REQ_PEEK:
                if (heap_fill == 0)
                begin
                    res.status = ST_EMPTY;
                    res.value  = INT_MIN;
                end
                else
                    res.value = heap_keys[0];
            default:
                ;
        endcase
        res.count = heap_fill[4:0];
        return res;
    endfunction

    // Keys weighted toward the extremes and a narrow band where ties are common.
    function automatic logic signed [31:0] random_key();
        case ($urandom_range(0, 7))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(0, 16)) - 8;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Drive one request beat and hold it until accepted; record what it must return.
    // Entered at a rising edge; returns at the edge that accepted the beat.
    task automatic send_request(input logic [2:0] req, input logic signed [31:0] key,
                                input logic [3:0] slot);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 13)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, slot, key};
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        due_results.push_back(heap_apply(req, key, slot));
    endtask

    // Peek, extract, decrease and delete against an empty heap, plus an unknown request code.
    task automatic test_empty_heap();
        send_request(REQ_PEEK, 32'sd0, 4'd0);
        send_request(REQ_EXTRACT, 32'sd0, 4'd0);
        send_request(REQ_DECREASE, 32'sd5, 4'd0);
        send_request(REQ_DELETE, 32'sd0, 4'd15);
        send_request(3'd7, 32'sd0, 4'd9);
    endtask

    // Extreme keys, a tie on decrease, a real decrease and a delete of the root.
    task automatic test_extreme_keys();
        send_request(REQ_INSERT, INT_MAX, 4'd0);
        send_request(REQ_INSERT, INT_MIN, 4'd0);
        send_request(REQ_INSERT, -32'sd1, 4'd0);
        send_request(REQ_PEEK, 32'sd0, 4'd0);
        send_request(REQ_DECREASE, -32'sd1, 4'd2);
        send_request(REQ_DECREASE, -32'sd5, 4'd1);
        send_request(REQ_DELETE, 32'sd0, 4'd0);
    endtask

    // Fill to capacity, insert once more, then delete the last slot.
    task automatic test_full_heap();
        while (heap_fill < CAPACITY)
            send_request(REQ_INSERT, random_key(), 4'($urandom_range(0, 15)));
        send_request(REQ_INSERT, 32'sd1, 4'd0);
        send_request(REQ_DELETE, 32'sd0, 4'd15);
    endtask

    // Random requests; the insert bias wanders so the heap swings between empty and full.
    task automatic test_random_traffic();
        int                 insert_bias;
        int                 pick;
        logic [2:0]         req;
        logic signed [31:0] key;
        logic [3:0]         slot;
        longint             lowered;
        insert_bias = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                insert_bias = $urandom_range(15, 85);
            // Run a long stretch with neither side idling.
            steady_flow = (n >= 150 && n < 250);
            key  = random_key();
            slot = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < insert_bias)
                req = REQ_INSERT;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: req = REQ_EXTRACT;
                    3, 4:    req = REQ_DECREASE;
                    5, 6:    req = REQ_DELETE;
                    7, 8:    req = REQ_PEEK;
                    default: req = 3'($urandom_range(5, 7));
                endcase
                // Aim most slot requests at held entries.
                if (heap_fill > 0 && $urandom_range(0, 9) != 0)
                    slot = 4'($urandom_range(0, heap_fill - 1));
                if (req == REQ_DECREASE && slot < heap_fill)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                    begin
                        lowered = longint'(heap_keys[slot]) - $urandom_range(1, 1000);
                        key = (lowered < longint'(INT_MIN)) ? INT_MIN : 32'(lowered);
                    end
                    else if (pick < 8)
                        key = heap_keys[slot];
                end
            end
            send_request(req, key, slot);
        end
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    // Stall the result side at random, except during the steady stretch.
    always @(posedge clk)
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 13);

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        heap_result_t want;
        heap_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value  = m_tdata[31:0];
            got.status = st_t'(m_tuser);
            got.count  = m_tdata[36:32];
            if (due_results.size() == 0)
            begin
                if (error_count < REPORT_MAX)
                    $display("unexpected result: value %0d status %0d count %0d",
                             got.value, got.status, got.count);
                error_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    if (error_count < REPORT_MAX)
                    begin
                        $write("mismatch: expected value %0d status %0d count %0d, ",
                               want.value, want.status, want.count);
                        $display("got value %0d status %0d count %0d",
                                 got.value, got.status, got.count);
                    end
                    error_count++;
                end
            end
        end
    end

    // Abort when neither side has moved a beat for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_heap();
        test_extreme_keys();
        test_full_heap();
        test_random_traffic();
        s_tvalid <= 1'b0;
        // Drain outstanding results, then watch for stray beats.
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
